FILE: hdl/ccs_pkg.sv
// shared types and constants of the c comment stripper
package ccs_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // one queue entry: the one or two results caused by one text byte
   typedef struct packed {
      logic [7:0] data0;
      logic       valid0;
      logic [7:0] data1;
      logic       two;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic in_quotes;
      logic quote_is_double;
      logic in_block_comment;
      logic in_line_comment;
      logic held_slash;
      logic held_star;
      logic escape_next;
   } scan_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/ccs_front.sv
// front part: classifies text bytes and builds queue entries
module ccs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  ccs_pkg::queue_status_type q_status,
   output logic               push,
   output ccs_pkg::entry_type push_entry
);

   ccs_pkg::scan_state_type state_ff, state_in;
   ccs_pkg::entry_type      entry;
   logic [1:0]              n;
   logic                    handle;
   logic                    accept;
   logic                    dq;

   function automatic ccs_pkg::entry_type put_byte(ccs_pkg::entry_type e, logic [1:0] cnt,
                                                   logic [7:0] x);
      ccs_pkg::entry_type r;
      r = e;
      if (cnt == 2'd0) begin
         r.data0  = x;
         r.valid0 = 1'b1;
      end else begin
         r.data1 = x;
      end
      return r;
   endfunction

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      entry    = '0;
      n        = 2'd0;
      handle   = 1'b1;
      dq       = (req_tdata == ccs_pkg::CH_DQUOTE);

      if (state_ff.in_line_comment) begin
         if (req_tdata == ccs_pkg::CH_NEWLINE) state_in.in_line_comment = 1'b0;
         handle = 1'b0;
      end else if (state_ff.escape_next) begin
         state_in.escape_next = 1'b0;
         entry  = put_byte(entry, n, req_tdata);
         n      = n + 2'd1;
         handle = 1'b0;
      end else if (state_ff.held_slash) begin
         state_in.held_slash = 1'b0;
         if (req_tdata == ccs_pkg::CH_SLASH) begin
            state_in.in_line_comment = 1'b1;
            handle = 1'b0;
         end else if (req_tdata == ccs_pkg::CH_STAR) begin
            state_in.in_block_comment = 1'b1;
            handle = 1'b0;
         end else if (!state_ff.in_block_comment) begin
            entry = put_byte(entry, n, ccs_pkg::CH_SLASH);
            n     = n + 2'd1;
         end
      end else if (state_ff.held_star) begin
         state_in.held_star = 1'b0;
         if (req_tdata == ccs_pkg::CH_SLASH) begin
            state_in.in_block_comment = 1'b0;
            handle = 1'b0;
         end
      end

      if (handle) begin
         priority if (req_tdata == ccs_pkg::CH_BACKSLASH) begin
            if (!state_in.in_block_comment) begin
               entry = put_byte(entry, n, req_tdata);
               n     = n + 2'd1;
               state_in.escape_next = 1'b1;
            end
         end else if (req_tdata == ccs_pkg::CH_SQUOTE || dq) begin
            if (!state_in.in_block_comment) begin
               entry = put_byte(entry, n, req_tdata);
               n     = n + 2'd1;
               if (!state_in.in_quotes) begin
                  state_in.in_quotes       = 1'b1;
                  state_in.quote_is_double = dq;
               end else if (state_in.quote_is_double == dq) begin
                  state_in.in_quotes       = 1'b0;
                  state_in.quote_is_double = 1'b0;
               end
            end
         end else if (req_tdata == ccs_pkg::CH_SLASH) begin
            if (state_in.in_quotes) begin
               entry = put_byte(entry, n, req_tdata);
               n     = n + 2'd1;
            end else begin
               state_in.held_slash = 1'b1;
            end
         end else if (req_tdata == ccs_pkg::CH_STAR) begin
            if (state_in.in_quotes || !state_in.in_block_comment) begin
               entry = put_byte(entry, n, req_tdata);
               n     = n + 2'd1;
            end else begin
               state_in.held_star = 1'b1;
            end
         end else if (!state_in.in_block_comment) begin
            entry = put_byte(entry, n, req_tdata);
            n     = n + 2'd1;
         end
      end

      if (req_tlast) begin
         if (state_in.held_slash && !state_in.in_block_comment) begin
            entry = put_byte(entry, n, ccs_pkg::CH_SLASH);
            n     = n + 2'd1;
         end
         // nothing kept for the final byte: send the end marker
         if (n == 2'd0) n = 2'd1;
         entry.last = 1'b1;
         state_in   = '0;
      end
      entry.two = (n == 2'd2);
   end

   assign push       = accept && (n != 2'd0);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/ccs_queue.sv
// short queue of result entries between front and back
module ccs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ccs_pkg::entry_type push_entry,
   input  logic               pop,
   output ccs_pkg::entry_type head,
   output ccs_pkg::queue_status_type status
);

   ccs_pkg::entry_type              mem_ff [ccs_pkg::QDEPTH];
   logic [ccs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ccs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ccs_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   localparam logic [ccs_pkg::QPTR_W-1:0] LAST_PTR = ccs_pkg::QPTR_W'(ccs_pkg::QDEPTH - 1);
   localparam logic [ccs_pkg::QCNT_W-1:0] FULL_CNT = ccs_pkg::QCNT_W'(ccs_pkg::QDEPTH);

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

FILE: hdl/ccs_back.sv
// back part: turns queue entries into single result transfers
module ccs_back (
   input  logic               clock,
   input  logic               reset,
   input  ccs_pkg::entry_type head,
   input  ccs_pkg::queue_status_type q_status,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   logic phase_ff, phase_in;
   logic xfer;
   logic final_part;

   assign rsp_tvalid = !q_status.empty;
   assign xfer       = rsp_tvalid && rsp_tready;
   // second half of a two-result entry, or the only half of a one-result entry
   assign final_part = phase_ff || !head.two;
   assign pop        = xfer && final_part;

   assign rsp_tdata = phase_ff ? head.data1 : head.data0;
   assign rsp_tuser = phase_ff ? 1'b1 : head.valid0;
   assign rsp_tlast = head.last && final_part;

   always_comb begin
      phase_in = phase_ff;
      if (xfer) phase_in = !final_part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   a_phase_has_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_status.empty && head.two))
      else $error("second half pending without a two-result entry");

   a_second_is_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && phase_ff) |-> rsp_tuser)
      else $error("second result of an entry must carry a byte");

   a_pop_clears_phase: assert property (@(posedge clock) disable iff (reset)
      pop |=> !phase_ff)
      else $error("phase not cleared after entry was taken");

endmodule

FILE: hdl/c_comment_stripper.sv
// top level of the c comment stripper
//
// Strips C-style comments from a byte stream. Each req_ transfer carries one
// text byte in req_tdata, with req_tlast on the final byte of a text. Each
// rsp_ transfer carries one kept byte in rsp_tdata with rsp_tuser high; an
// end marker (rsp_tuser low, rsp_tdata zero) closes a text whose final byte
// left nothing to send. rsp_tlast marks the final result of a text.
//
// A byte is classified in the cycle it is accepted and its results are
// written to a two-entry queue, from whose head rsp_ is driven. One byte is
// accepted per cycle while the queue is not full. A byte that releases a held
// slash gives two results, sent as two rsp_ transfers; with bytes back to
// back the queue may then fill and hold req_tready low. Bytes inside comments
// give no result, except the end marker when one is the final byte of a text.
//
// Reset clears the scanner state and the queue. When the receiver stalls,
// the queue fills and req_tready drops once both entries are taken; the
// current result holds on rsp_ until it is transferred.
module c_comment_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] out_valid_byte
   output logic       rsp_tlast
);

   ccs_pkg::queue_status_type q_status;
   ccs_pkg::entry_type        push_entry;
   ccs_pkg::entry_type        head;
   logic                      push;
   logic                      pop;

   ccs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   ccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   ccs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
